>>> hdl/led_effect_sequencer_assert.svh
// ----------------------------------------------------------------------------
// led effect sequencer assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef LED_EFFECT_SEQUENCER_ASSERT_SVH
`define LED_EFFECT_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define LES_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define LES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/les_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// types, codes and constants shared by the led effect sequencer
// ----------------------------------------------------------------------------
package les_pkg;

   localparam int LEVEL_W = 8;
   localparam int DWELL_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int MODE_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MODE_W-1:0] MODE_MANUAL         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STROBE_WHITE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STROBE_RANDOM  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STROBE_BASE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BREATHE_WHITE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BREATHE_BASE   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SWEEP          = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE_SELECT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_WORD      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STROBE_ON_MS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STROBE_OFF_MS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BREATHE_PERIOD  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SWEEP_STEP_MS   = 3'd5;

   localparam logic [DWELL_W-1:0] STROBE_ON_RESET   = 16'd10;
   localparam logic [DWELL_W-1:0] STROBE_OFF_RESET  = 16'd100;
   localparam logic [LEVEL_W-1:0] BREATHE_RESET     = 8'd1;
   localparam logic [DWELL_W-1:0] SWEEP_STEP_RESET  = 16'd100;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
   localparam int HUE_SECTOR = 43;

   // period*1000/510 == (period*BREATHE_RECIP) >> BREATHE_SHIFT for 8-bit periods
   localparam int BREATHE_SHIFT = 14;
   localparam int BREATHE_RECIP_W = 15;
   localparam logic [BREATHE_RECIP_W-1:0] BREATHE_RECIP = 15'd32126;

   typedef enum logic [2:0] {
      OP_MANUAL,
      OP_STROBE_OFF,
      OP_STROBE_WHITE,
      OP_STROBE_RANDOM,
      OP_STROBE_BASE,
      OP_BREATHE_WHITE,
      OP_BREATHE_BASE,
      OP_SWEEP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] rnd_red;
      logic [LEVEL_W-1:0] rnd_green;
      logic [LEVEL_W-1:0] rnd_blue;
   } cmd_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] color_word;
      logic [DWELL_W-1:0]    strobe_on_ms;
      logic [DWELL_W-1:0]    strobe_off_ms;
      logic [LEVEL_W-1:0]    breathe_period_s;
      logic [DWELL_W-1:0]    sweep_step_ms;
   } cfg_type;

endpackage

>>> hdl/led_effect_sequencer.sv
`timescale 1ns / 1ps
// a pushed beat passes through the command queue and then the output register to the result ports
// throughput: one beat per cycle while the queue is not full and results are popped, set by the back part
// the command queue and the output register let either side stall alone
// reset: synchronous, clears queue, output valid flag and effect state,
// and loads the register defaults
// ----------------------------------------------------------------------------
// led_effect_sequencer
// rgbw lamp effect sequencer: strobe, breathing and hue sweep steps
// ----------------------------------------------------------------------------
`include "led_effect_sequencer_assert.svh"

module led_effect_sequencer #(
   parameter int QUEUE_DEPTH = les_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [les_pkg::LEVEL_W-1:0]       req_random_red,
   input  logic [les_pkg::LEVEL_W-1:0]       req_random_green,
   input  logic [les_pkg::LEVEL_W-1:0]       req_random_blue,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [les_pkg::LEVEL_W-1:0]       rsp_red_level,
   output logic [les_pkg::LEVEL_W-1:0]       rsp_green_level,
   output logic [les_pkg::LEVEL_W-1:0]       rsp_blue_level,
   output logic [les_pkg::LEVEL_W-1:0]       rsp_white_level,
   output logic [les_pkg::DWELL_W-1:0]       rsp_dwell_ms,
   input  logic                              csr_write_en,
   input  logic [les_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [les_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import les_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   cfg_type           cfg_ff;
   logic              req_accept;
   cmd_type           front_cmd, q_cmd;
   logic              q_valid, q_take;

   assign req_accept = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff                 <= MODE_MANUAL;
         cfg_ff.color_word       <= '0;
         cfg_ff.strobe_on_ms     <= STROBE_ON_RESET;
         cfg_ff.strobe_off_ms    <= STROBE_OFF_RESET;
         cfg_ff.breathe_period_s <= BREATHE_RESET;
         cfg_ff.sweep_step_ms    <= SWEEP_STEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MODE_SELECT:    mode_ff                 <= csr_wdata[MODE_W-1:0];
            REG_COLOR_WORD:     cfg_ff.color_word       <= csr_wdata;
            REG_STROBE_ON_MS:   cfg_ff.strobe_on_ms     <= csr_wdata[DWELL_W-1:0];
            REG_STROBE_OFF_MS:  cfg_ff.strobe_off_ms    <= csr_wdata[DWELL_W-1:0];
            REG_BREATHE_PERIOD: cfg_ff.breathe_period_s <= csr_wdata[LEVEL_W-1:0];
            REG_SWEEP_STEP_MS:  cfg_ff.sweep_step_ms    <= csr_wdata[DWELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   les_front u_front (
      .clock        (clock),
      .reset        (reset),
      .mode_select  (mode_ff),
      .accept       (req_accept),
      .random_red   (req_random_red),
      .random_green (req_random_green),
      .random_blue  (req_random_blue),
      .cmd          (front_cmd)
   );

   les_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (q_take),
      .pop_data  (q_cmd),
      .valid     (q_valid)
   );

   les_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (q_valid),
      .cmd             (q_cmd),
      .cmd_take        (q_take),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .rsp_white_level (rsp_white_level),
      .rsp_dwell_ms    (rsp_dwell_ms)
   );

   `LES_ASSERT_NEXT(a_beat_reaches_queue, req_accept, q_valid, "accepted beat lost before queue")
   `LES_ASSERT_NEXT(a_no_phantom_rsp, rsp_empty && !q_valid, rsp_empty, "result without queued beat")
   `LES_ASSERT_NEXT(a_back_drains, q_valid && rsp_empty, !rsp_empty, "back part idle with work queued")
   `LES_ASSERT_SAME(a_take_needs_cmd, q_take, q_valid, "back part took from empty queue")

endmodule

>>> hdl/les_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_front
// accepts effect steps, advances the running effect state and issues commands
// ----------------------------------------------------------------------------
module les_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [les_pkg::MODE_W-1:0]    mode_select,
   input  logic                          accept,
   input  logic [les_pkg::LEVEL_W-1:0]   random_red,
   input  logic [les_pkg::LEVEL_W-1:0]   random_green,
   input  logic [les_pkg::LEVEL_W-1:0]   random_blue,
   output les_pkg::cmd_type              cmd
);
   import les_pkg::*;

   logic               strobe_on_next_ff, strobe_on_next_in;
   logic [LEVEL_W-1:0] breathe_level_ff, breathe_level_in;
   logic               breathe_rising_ff, breathe_rising_in;
   logic [LEVEL_W-1:0] sweep_hue_ff, sweep_hue_in;
   logic [LEVEL_W-1:0] breathe_step;

   always_comb begin
      strobe_on_next_in = strobe_on_next_ff;
      breathe_level_in  = breathe_level_ff;
      breathe_rising_in = breathe_rising_ff;
      sweep_hue_in      = sweep_hue_ff;
      breathe_step      = breathe_rising_ff ? breathe_level_ff + 8'd1
                                            : breathe_level_ff - 8'd1;
      cmd.op        = OP_MANUAL;
      cmd.level     = '0;
      cmd.rnd_red   = random_red;
      cmd.rnd_green = random_green;
      cmd.rnd_blue  = random_blue;
      unique case (mode_select)
         MODE_STROBE_WHITE, MODE_STROBE_RANDOM, MODE_STROBE_BASE: begin
            strobe_on_next_in = !strobe_on_next_ff;
            if (!strobe_on_next_ff) begin
               cmd.op = OP_STROBE_OFF;
            end else if (mode_select == MODE_STROBE_WHITE) begin
               cmd.op = OP_STROBE_WHITE;
            end else if (mode_select == MODE_STROBE_RANDOM) begin
               cmd.op = OP_STROBE_RANDOM;
            end else begin
               cmd.op = OP_STROBE_BASE;
            end
         end
         MODE_BREATHE_WHITE, MODE_BREATHE_BASE: begin
            breathe_level_in = breathe_step;
            if (breathe_step == '0 || breathe_step == LEVEL_MAX) begin
               breathe_rising_in = !breathe_rising_ff;
            end
            cmd.level = breathe_step;
            cmd.op    = (mode_select == MODE_BREATHE_WHITE) ? OP_BREATHE_WHITE
                                                            : OP_BREATHE_BASE;
         end
         MODE_SWEEP: begin
            sweep_hue_in = sweep_hue_ff + 8'd1;
            cmd.level    = sweep_hue_ff;
            cmd.op       = OP_SWEEP;
         end
         default: begin
            cmd.op = OP_MANUAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_on_next_ff <= 1'b1;
         breathe_level_ff  <= '0;
         breathe_rising_ff <= 1'b1;
         sweep_hue_ff      <= '0;
      end else if (accept) begin
         strobe_on_next_ff <= strobe_on_next_in;
         breathe_level_ff  <= breathe_level_in;
         breathe_rising_ff <= breathe_rising_in;
         sweep_hue_ff      <= sweep_hue_in;
      end
   end

endmodule

>>> hdl/les_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_fifo
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module les_fifo #(
   parameter int DEPTH = les_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  les_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output les_pkg::cmd_type pop_data,
   output logic             valid
);
   import les_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/les_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_back
// turns queued commands into drive levels and dwell, one per cycle while results are popped
// ----------------------------------------------------------------------------
module les_back (
   input  logic                          clock,
   input  logic                          reset,
   input  les_pkg::cfg_type              cfg,
   input  logic                          cmd_valid,
   input  les_pkg::cmd_type              cmd,
   output logic                          cmd_take,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [les_pkg::LEVEL_W-1:0]   rsp_red_level,
   output logic [les_pkg::LEVEL_W-1:0]   rsp_green_level,
   output logic [les_pkg::LEVEL_W-1:0]   rsp_blue_level,
   output logic [les_pkg::LEVEL_W-1:0]   rsp_white_level,
   output logic [les_pkg::DWELL_W-1:0]   rsp_dwell_ms
);
   import les_pkg::*;

   localparam int PROD_W = 2 * LEVEL_W;
   localparam int RECIP_PROD_W = LEVEL_W + BREATHE_RECIP_W;

   // v*255 >> 8
   function automatic logic [LEVEL_W-1:0] scale255(input logic [LEVEL_W-1:0] v);
      logic [PROD_W-1:0] p;
      p = {v, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, v};
      return p[PROD_W-1:LEVEL_W];
   endfunction

   // exact x/255 for x up to 255*255, the largest product of two levels
   function automatic logic [LEVEL_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = {1'b0, x} + {{(LEVEL_W + 1){1'b0}}, x[PROD_W-1:LEVEL_W]} + 1'b1;
      return s[PROD_W-1:LEVEL_W];
   endfunction

   function automatic logic [LEVEL_W-1:0] fade(input logic [LEVEL_W-1:0] c,
                                                input logic [LEVEL_W-1:0] lvl);
      logic [PROD_W-1:0] p;
      p = c * lvl;
      return div255(p);
   endfunction

   logic                  out_valid_ff;
   logic [LEVEL_W-1:0]    red_ff, green_ff, blue_ff, white_ff;
   logic [DWELL_W-1:0]    dwell_ff;
   logic [LEVEL_W-1:0]    red_in, green_in, blue_in, white_in;
   logic [DWELL_W-1:0]    dwell_in;
   logic [LEVEL_W-1:0]    base_w, base_r, base_g, base_b;
   logic [2:0]            sector;
   logic [LEVEL_W-1:0]    sector_base, frac, fall, rise;
   logic [RECIP_PROD_W-1:0] breathe_prod;
   logic [DWELL_W-1:0]    breathe_dwell;

   assign base_w = cfg.color_word[7:0];
   assign base_r = cfg.color_word[15:8];
   assign base_g = cfg.color_word[23:16];
   assign base_b = cfg.color_word[31:24];

   assign cmd_take  = cmd_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_green_level = green_ff;
   assign rsp_blue_level  = blue_ff;
   assign rsp_white_level = white_ff;
   assign rsp_dwell_ms    = dwell_ff;

   assign breathe_prod  = cfg.breathe_period_s * BREATHE_RECIP;
   assign breathe_dwell = DWELL_W'(breathe_prod[RECIP_PROD_W-1:BREATHE_SHIFT]);

   // hue sector and position within it
   always_comb begin
      if (cmd.level >= LEVEL_W'(5 * HUE_SECTOR)) begin
         sector = 3'd5;
         sector_base = LEVEL_W'(5 * HUE_SECTOR);
      end else if (cmd.level >= LEVEL_W'(4 * HUE_SECTOR)) begin
         sector = 3'd4;
         sector_base = LEVEL_W'(4 * HUE_SECTOR);
      end else if (cmd.level >= LEVEL_W'(3 * HUE_SECTOR)) begin
         sector = 3'd3;
         sector_base = LEVEL_W'(3 * HUE_SECTOR);
      end else if (cmd.level >= LEVEL_W'(2 * HUE_SECTOR)) begin
         sector = 3'd2;
         sector_base = LEVEL_W'(2 * HUE_SECTOR);
      end else if (cmd.level >= LEVEL_W'(HUE_SECTOR)) begin
         sector = 3'd1;
         sector_base = LEVEL_W'(HUE_SECTOR);
      end else begin
         sector = 3'd0;
         sector_base = '0;
      end
      frac = LEVEL_W'((cmd.level - sector_base) * 3'd6);
      fall = scale255(LEVEL_MAX - scale255(frac));
      rise = scale255(LEVEL_MAX - scale255(LEVEL_MAX - frac));
   end

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      white_in = '0;
      dwell_in = '0;
      unique case (cmd.op)
         OP_STROBE_OFF: begin
            dwell_in = cfg.strobe_off_ms;
         end
         OP_STROBE_WHITE: begin
            white_in = LEVEL_MAX;
            dwell_in = cfg.strobe_on_ms;
         end
         OP_STROBE_RANDOM: begin
            red_in   = cmd.rnd_red;
            green_in = cmd.rnd_green;
            blue_in  = cmd.rnd_blue;
            dwell_in = cfg.strobe_on_ms;
         end
         OP_STROBE_BASE: begin
            red_in   = base_r;
            green_in = base_g;
            blue_in  = base_b;
            white_in = base_w;
            dwell_in = cfg.strobe_on_ms;
         end
         OP_BREATHE_WHITE: begin
            white_in = cmd.level;
            dwell_in = breathe_dwell;
         end
         OP_BREATHE_BASE: begin
            red_in   = fade(base_r, cmd.level);
            green_in = fade(base_g, cmd.level);
            blue_in  = fade(base_b, cmd.level);
            white_in = fade(base_w, cmd.level);
            dwell_in = breathe_dwell;
         end
         OP_SWEEP: begin
            white_in = base_w;
            dwell_in = cfg.sweep_step_ms;
            case (sector)
               3'd0: begin
                  red_in = LEVEL_MAX; green_in = rise;
               end
               3'd1: begin
                  red_in = fall; green_in = LEVEL_MAX;
               end
               3'd2: begin
                  green_in = LEVEL_MAX; blue_in = rise;
               end
               3'd3: begin
                  green_in = fall; blue_in = LEVEL_MAX;
               end
               3'd4: begin
                  red_in = rise; blue_in = LEVEL_MAX;
               end
               default: begin
                  red_in = LEVEL_MAX; blue_in = fall;
               end
            endcase
         end
         default: begin
            red_in   = base_r;
            green_in = base_g;
            blue_in  = base_b;
            white_in = base_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd_take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         white_ff <= white_in;
         dwell_ff <= dwell_in;
      end
   end

endmodule
